// ===== rtl/ezr_pkg.sv =====
// Shared constants, tables, types and arithmetic helpers of the Euler ZYX to rotation matrix unit.
package ezr_pkg;

    localparam int ANGLE_W         = 16;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int OUT_W           = 16;
    localparam int N_AXES          = 3;
    localparam int N_ENTRIES       = 9;

    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    // Angle folding: the angle plus whole turns, divided into a 32-bit binary angle.
    localparam int     FULL_TURN = 360 << ANGLE_FRAC_BITS;
    localparam int     BIAS      = ((32768 + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
    localparam int     FOLD_W    = $clog2(32768 + BIAS);
    localparam int     DIV_D     = 45;
    localparam int     DIV_HALF  = 22;
    localparam int     REC_K     = FOLD_W + 7;
    localparam longint REC_M     = ((longint'(1) << REC_K) + DIV_D - 1) / DIV_D;
    localparam int     REC_M_W   = REC_K - 4;
    localparam int     QUOT_W    = FOLD_W - 5;
    localparam int     REM_W     = 6;
    localparam int     TURN_SH   = 29 - ANGLE_FRAC_BITS;
    localparam int     ZF_W      = 30;

    typedef logic [ZF_W-1:0] t_rem_tab [DIV_D];

    function automatic t_rem_tab f_rem_tab();
        t_rem_tab tab;
        for (int g = 0; g < DIV_D; g++) begin
            tab[g] = ZF_W'(((longint'(g) << TURN_SH) + DIV_HALF) / DIV_D);
        end
        return tab;
    endfunction

    localparam t_rem_tab REM_TAB = f_rem_tab();

    // CORDIC.
    localparam int CORDIC_ITERS = 32;
    localparam int XY_W         = 35;
    localparam int Z_W          = 32;
    localparam int SC_W         = 32;
    localparam logic signed [XY_W-1:0] CORDIC_K = XY_W'(64'd2608131496);

    localparam logic [30:0] ATAN_TURN [CORDIC_ITERS] = '{
        31'h20000000, 31'h12E4051E, 31'h09FB385B, 31'h051111D4, 31'h028B0D43, 31'h0145D7E1,
        31'h00A2F61E, 31'h00517C55, 31'h0028BE53, 31'h00145F2F, 31'h000A2F98, 31'h000517CC,
        31'h00028BE6, 31'h000145F3, 31'h0000A2FA, 31'h0000517D, 31'h000028BE, 31'h0000145F,
        31'h00000A30, 31'h00000518, 31'h0000028C, 31'h00000146, 31'h000000A3, 31'h00000051,
        31'h00000029, 31'h00000014, 31'h0000000A, 31'h00000005, 31'h00000003, 31'h00000001,
        31'h00000001, 31'h00000000
    };

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Matrix products.
    localparam int     MQ_W    = 34;
    localparam int     PP_W    = MQ_W + SC_W;
    localparam int     SUM_W   = MQ_W + 1;
    localparam longint RND30   = longint'(1) << 29;
    localparam longint OUT_RND = (OUT_FRAC_BITS < 30) ?
                                 (longint'(1) << (29 - OUT_FRAC_BITS % 30)) : 0;
    localparam int     OUT_SH  = 30 - OUT_FRAC_BITS;
    localparam longint SAT_ONE = longint'(1) << OUT_FRAC_BITS;
    localparam longint SAT_HI  = (SAT_ONE > 32767) ? 32767 : SAT_ONE;
    localparam longint SAT_LO  = (-SAT_ONE < -32768) ? -32768 : -SAT_ONE;

    typedef struct packed {
        logic [N_AXES-1:0][1:0]      quad;
        logic [N_AXES-1:0][ZF_W-1:0] ang;
    } t_fold;

    typedef struct packed {
        logic [N_AXES-1:0][SC_W-1:0] s;
        logic [N_AXES-1:0][SC_W-1:0] c;
    } t_trig;

    function automatic logic signed [MQ_W-1:0] f_rnd(input logic signed [PP_W-1:0] p);
        logic signed [PP_W-1:0] t;
        t = p + PP_W'(RND30);
        return MQ_W'(t >>> 30);
    endfunction

    function automatic logic [OUT_W-1:0] f_to_out(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W:0] t;
        t = ((SUM_W+1)'(v) + (SUM_W+1)'(OUT_RND)) >>> OUT_SH;
        if (t > (SUM_W+1)'(SAT_HI)) begin
            return OUT_W'(SAT_HI);
        end else if (t < (SUM_W+1)'(SAT_LO)) begin
            return OUT_W'(SAT_LO);
        end
        return t[OUT_W-1:0];
    endfunction

endpackage

// ===== rtl/ezr_fold.sv =====
// Four-stage fold of three angles into quadrant and first-quadrant binary angle.
module ezr_fold (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_valid,
    output logic                                                 o_ready,
    input  logic [ezr_pkg::N_AXES-1:0][ezr_pkg::ANGLE_W-1:0]     i_ang,
    output logic                                                 o_valid,
    input  logic                                                 i_ready,
    output ezr_pkg::t_fold                                       o_fold
);

    localparam int NST = 4;
    localparam int NA  = ezr_pkg::N_AXES;
    localparam int FW  = ezr_pkg::FOLD_W;
    localparam int PW  = ezr_pkg::FOLD_W + ezr_pkg::REC_M_W;

    logic [NST-1:0] r_v;
    logic [NST:0]   w_rdy;
    logic [NST-1:0] w_vin;
    logic [NST-1:0] w_ld;

    logic [FW-1:0]                    r_a0 [NA];
    logic [FW-1:0]                    r_a1 [NA];
    logic [PW-1:0]                    r_p  [NA];
    logic [ezr_pkg::QUOT_W-1:0]       r_h  [NA];
    logic [ezr_pkg::REM_W-1:0]        r_g  [NA];
    ezr_pkg::t_fold                   r_out;

    logic [FW:0]                      w_a   [NA];
    logic [ezr_pkg::QUOT_W-1:0]       w_h   [NA];
    logic [FW-1:0]                    w_rem [NA];
    logic [31:0]                      w_w   [NA];

    assign w_rdy[NST] = i_ready;
    assign w_vin[0]   = i_valid;

    for (genvar k = 0; k < NST; k++) begin : g_ctl
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
        assign w_ld[k]  = w_rdy[k] && w_vin[k];
        if (k > 0) begin : g_vin
            assign w_vin[k] = r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NA; l++) begin
            w_a[l]   = (FW+1)'($signed(i_ang[l])) + (FW+1)'(ezr_pkg::BIAS);
            w_h[l]   = r_p[l][ezr_pkg::REC_K +: ezr_pkg::QUOT_W];
            w_rem[l] = r_a1[l] - FW'(FW'(w_h[l]) * FW'(ezr_pkg::DIV_D));
            w_w[l]   = (32'(r_h[l]) << ezr_pkg::TURN_SH) + 32'(ezr_pkg::REM_TAB[r_g[l]]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NA; l++) begin
            if (w_ld[0]) begin
                r_a0[l] <= w_a[l][FW-1:0];
            end
            if (w_ld[1]) begin
                r_a1[l] <= r_a0[l];
                r_p[l]  <= PW'(r_a0[l]) * PW'(ezr_pkg::REC_M);
            end
            if (w_ld[2]) begin
                r_h[l] <= w_h[l];
                r_g[l] <= w_rem[l][ezr_pkg::REM_W-1:0];
            end
            if (w_ld[3]) begin
                r_out.quad[l] <= w_w[l][31:30];
                r_out.ang[l]  <= w_w[l][ezr_pkg::ZF_W-1:0];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NST-1];
    assign o_fold  = r_out;

endmodule

// ===== rtl/ezr_cordic.sv =====
// Unrolled rotation-mode CORDIC over three lanes with final rounding and quadrant mapping.
module ezr_cordic (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ezr_pkg::t_fold  i_fold,
    output logic            o_valid,
    input  logic            i_ready,
    output ezr_pkg::t_trig  o_trig
);

    localparam int NIT = ezr_pkg::CORDIC_ITERS;
    localparam int NST = NIT + 1;
    localparam int NA  = ezr_pkg::N_AXES;
    localparam int XW  = ezr_pkg::XY_W;
    localparam int ZW  = ezr_pkg::Z_W;
    localparam int SW  = ezr_pkg::SC_W;

    logic [NST-1:0] r_v;
    logic [NST:0]   w_rdy;
    logic [NST-1:0] w_vin;
    logic [NST-1:0] w_ld;

    logic signed [XW-1:0]   r_x [NIT][NA];
    logic signed [XW-1:0]   r_y [NIT][NA];
    logic signed [ZW-1:0]   r_z [NIT][NA];
    logic [NA-1:0][1:0]     r_q [NIT];
    ezr_pkg::t_trig         r_out;

    assign w_rdy[NST] = i_ready;
    assign w_vin[0]   = i_valid;

    for (genvar k = 0; k < NST; k++) begin : g_ctl
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
        assign w_ld[k]  = w_rdy[k] && w_vin[k];
        if (k > 0) begin : g_vin
            assign w_vin[k] = r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    for (genvar i = 0; i < NIT; i++) begin : g_it
        logic [NA-1:0][1:0] w_qin;
        if (i == 0) begin : g_q0
            assign w_qin = i_fold.quad;
        end else begin : g_qn
            assign w_qin = r_q[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_ld[i]) begin
                r_q[i] <= w_qin;
            end
        end

        for (genvar l = 0; l < NA; l++) begin : g_ln
            logic signed [XW-1:0] w_xi;
            logic signed [XW-1:0] w_yi;
            logic signed [ZW-1:0] w_zi;
            logic signed [XW-1:0] w_dx;
            logic signed [XW-1:0] w_dy;
            logic signed [ZW-1:0] w_at;

            if (i == 0) begin : g_init
                assign w_xi = ezr_pkg::CORDIC_K;
                assign w_yi = '0;
                assign w_zi = ZW'(i_fold.ang[l]);
            end else begin : g_next
                assign w_xi = r_x[i-1][l];
                assign w_yi = r_y[i-1][l];
                assign w_zi = r_z[i-1][l];
            end

            assign w_dx = w_yi >>> i;
            assign w_dy = w_xi >>> i;
            assign w_at = ZW'(ezr_pkg::ATAN_TURN[i]);

            always_ff @(posedge i_clk) begin
                if (w_ld[i]) begin
                    if (!w_zi[ZW-1]) begin
                        r_x[i][l] <= w_xi - w_dx;
                        r_y[i][l] <= w_yi + w_dy;
                        r_z[i][l] <= w_zi - w_at;
                    end else begin
                        r_x[i][l] <= w_xi + w_dx;
                        r_y[i][l] <= w_yi - w_dy;
                        r_z[i][l] <= w_zi + w_at;
                    end
                end
            end
        end
    end

    for (genvar l = 0; l < NA; l++) begin : g_post
        logic signed [XW-1:0] w_cr;
        logic signed [XW-1:0] w_sr;
        logic signed [SW-1:0] w_c;
        logic signed [SW-1:0] w_s;
        logic signed [SW-1:0] n_c;
        logic signed [SW-1:0] n_s;

        assign w_cr = (r_x[NIT-1][l] + XW'(2)) >>> 2;
        assign w_sr = (r_y[NIT-1][l] + XW'(2)) >>> 2;
        assign w_c  = SW'(w_cr);
        assign w_s  = SW'(w_sr);

        always_comb begin
            unique case (r_q[NIT-1][l])
                ezr_pkg::QUAD_0: begin
                    n_c = w_c;
                    n_s = w_s;
                end
                ezr_pkg::QUAD_1: begin
                    n_c = -w_s;
                    n_s = w_c;
                end
                ezr_pkg::QUAD_2: begin
                    n_c = -w_c;
                    n_s = -w_s;
                end
                ezr_pkg::QUAD_3: begin
                    n_c = w_s;
                    n_s = -w_c;
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (w_ld[NIT]) begin
                r_out.c[l] <= n_c;
                r_out.s[l] <= n_s;
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NST-1];
    assign o_trig  = r_out;

endmodule

// ===== rtl/ezr_matrix.sv =====
// Six-stage product, rounding, summing and saturation pipeline for the nine matrix entries.
module ezr_matrix (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  logic                                                    i_valid,
    output logic                                                    o_ready,
    input  ezr_pkg::t_trig                                          i_trig,
    output logic                                                    o_valid,
    input  logic                                                    i_ready,
    output logic [ezr_pkg::N_ENTRIES-1:0][ezr_pkg::OUT_W-1:0]       o_ent
);

    localparam int NST = 6;
    localparam int NP  = 10;
    localparam int NQ  = 4;
    localparam int NE  = ezr_pkg::N_ENTRIES;
    localparam int SW  = ezr_pkg::SC_W;
    localparam int MW  = ezr_pkg::MQ_W;
    localparam int PW  = ezr_pkg::PP_W;
    localparam int UW  = ezr_pkg::SUM_W;

    localparam int I_CZSY = 0;
    localparam int I_SZSY = 1;
    localparam int I_CZCY = 2;
    localparam int I_SZCY = 3;
    localparam int I_CYSX = 4;
    localparam int I_CYCX = 5;
    localparam int I_SZCX = 6;
    localparam int I_SZSX = 7;
    localparam int I_CZCX = 8;
    localparam int I_CZSX = 9;

    logic [NST-1:0] r_v;
    logic [NST:0]   w_rdy;
    logic [NST-1:0] w_vin;
    logic [NST-1:0] w_ld;

    logic signed [SW-1:0] w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;

    logic signed [PW-1:0]   r_p0 [NP];
    logic signed [SW-1:0]   r_sx0, r_cx0, r_sy0;
    logic signed [MW-1:0]   r_m1 [NP];
    logic signed [SW-1:0]   r_sx1, r_cx1, r_sy1;
    logic signed [PW-1:0]   r_q2 [NQ];
    logic signed [MW-1:0]   r_m2 [NP];
    logic signed [SW-1:0]   r_sy2;
    logic signed [MW-1:0]   r_r3 [NQ];
    logic signed [MW-1:0]   r_m3 [NP];
    logic signed [SW-1:0]   r_sy3;
    logic signed [UW-1:0]   r_s4 [NE];
    logic [ezr_pkg::OUT_W-1:0] r_o [NE];

    assign w_sx = $signed(i_trig.s[ezr_pkg::AX_X]);
    assign w_cx = $signed(i_trig.c[ezr_pkg::AX_X]);
    assign w_sy = $signed(i_trig.s[ezr_pkg::AX_Y]);
    assign w_cy = $signed(i_trig.c[ezr_pkg::AX_Y]);
    assign w_sz = $signed(i_trig.s[ezr_pkg::AX_Z]);
    assign w_cz = $signed(i_trig.c[ezr_pkg::AX_Z]);

    assign w_rdy[NST] = i_ready;
    assign w_vin[0]   = i_valid;

    for (genvar k = 0; k < NST; k++) begin : g_ctl
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
        assign w_ld[k]  = w_rdy[k] && w_vin[k];
        if (k > 0) begin : g_vin
            assign w_vin[k] = r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_p0[I_CZSY] <= PW'(w_cz) * PW'(w_sy);
            r_p0[I_SZSY] <= PW'(w_sz) * PW'(w_sy);
            r_p0[I_CZCY] <= PW'(w_cz) * PW'(w_cy);
            r_p0[I_SZCY] <= PW'(w_sz) * PW'(w_cy);
            r_p0[I_CYSX] <= PW'(w_cy) * PW'(w_sx);
            r_p0[I_CYCX] <= PW'(w_cy) * PW'(w_cx);
            r_p0[I_SZCX] <= PW'(w_sz) * PW'(w_cx);
            r_p0[I_SZSX] <= PW'(w_sz) * PW'(w_sx);
            r_p0[I_CZCX] <= PW'(w_cz) * PW'(w_cx);
            r_p0[I_CZSX] <= PW'(w_cz) * PW'(w_sx);
            r_sx0 <= w_sx;
            r_cx0 <= w_cx;
            r_sy0 <= w_sy;
        end
        if (w_ld[1]) begin
            for (int k = 0; k < NP; k++) begin
                r_m1[k] <= ezr_pkg::f_rnd(r_p0[k]);
            end
            r_sx1 <= r_sx0;
            r_cx1 <= r_cx0;
            r_sy1 <= r_sy0;
        end
        if (w_ld[2]) begin
            r_q2[0] <= PW'(r_m1[I_CZSY]) * PW'(r_sx1);
            r_q2[1] <= PW'(r_m1[I_CZSY]) * PW'(r_cx1);
            r_q2[2] <= PW'(r_m1[I_SZSY]) * PW'(r_sx1);
            r_q2[3] <= PW'(r_m1[I_SZSY]) * PW'(r_cx1);
            r_m2  <= r_m1;
            r_sy2 <= r_sy1;
        end
        if (w_ld[3]) begin
            for (int j = 0; j < NQ; j++) begin
                r_r3[j] <= ezr_pkg::f_rnd(r_q2[j]);
            end
            r_m3  <= r_m2;
            r_sy3 <= r_sy2;
        end
        if (w_ld[4]) begin
            r_s4[0] <= UW'(r_m3[I_CZCY]);
            r_s4[1] <= UW'(r_r3[0]) - UW'(r_m3[I_SZCX]);
            r_s4[2] <= UW'(r_r3[1]) + UW'(r_m3[I_SZSX]);
            r_s4[3] <= UW'(r_m3[I_SZCY]);
            r_s4[4] <= UW'(r_r3[2]) + UW'(r_m3[I_CZCX]);
            r_s4[5] <= UW'(r_r3[3]) - UW'(r_m3[I_CZSX]);
            r_s4[6] <= -UW'(r_sy3);
            r_s4[7] <= UW'(r_m3[I_CYSX]);
            r_s4[8] <= UW'(r_m3[I_CYCX]);
        end
        if (w_ld[5]) begin
            for (int e = 0; e < NE; e++) begin
                r_o[e] <= ezr_pkg::f_to_out(r_s4[e]);
            end
        end
    end

    for (genvar e = 0; e < NE; e++) begin : g_out
        assign o_ent[e] = r_o[e];
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NST-1];

endmodule

// ===== rtl/euler_zyx_to_rotation_matrix_unit.sv =====
// Top level of the Euler ZYX angle to rotation matrix unit.
//
// The slave stream takes one beat per angle triple: roll, pitch and yaw in
// degrees with six fraction bits, any 16-bit value wrapping modulo a turn.
// The master stream gives one beat per triple: the nine entries of
// Rz(yaw) * Ry(pitch) * Rx(roll) in signed Q1.14, saturated to plus or minus one.
// A beat enters in every cycle unless the pipeline is full and the receiver
// stalls. Each result passes through angle folding, 32 CORDIC iterations and a
// rounding step, then products, sums and saturation.
// Every stage has its own valid bit and takes new data whenever it is empty or
// the stage after it moves, so bubbles close up and the input keeps accepting
// while a finished result waits at the output.
// When the receiver stalls, the pipeline fills and then holds every beat;
// nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
module euler_zyx_to_rotation_matrix_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [47:0]  i_s_axis_tdata,   // roll_deg, pitch_deg, yaw_deg
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [143:0] o_m_axis_tdata    // r00, r01, r02, r10, r11, r12, r20, r21, r22
);

    localparam int NA = ezr_pkg::N_AXES;
    localparam int AW = ezr_pkg::ANGLE_W;
    localparam int OW = ezr_pkg::OUT_W;
    localparam int NE = ezr_pkg::N_ENTRIES;

    logic [NA-1:0][AW-1:0] w_ang;
    logic                  w_fold_valid;
    logic                  w_fold_ready;
    ezr_pkg::t_fold        w_fold;
    logic                  w_trig_valid;
    logic                  w_trig_ready;
    ezr_pkg::t_trig        w_trig;
    logic [NE-1:0][OW-1:0] w_ent;

    for (genvar l = 0; l < NA; l++) begin : g_ang
        assign w_ang[l] = i_s_axis_tdata[l*AW +: AW];
    end

    ezr_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_ang   (w_ang),
        .o_valid (w_fold_valid),
        .i_ready (w_fold_ready),
        .o_fold  (w_fold)
    );

    ezr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fold_valid),
        .o_ready (w_fold_ready),
        .i_fold  (w_fold),
        .o_valid (w_trig_valid),
        .i_ready (w_trig_ready),
        .o_trig  (w_trig)
    );

    ezr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_trig_valid),
        .o_ready (w_trig_ready),
        .i_trig  (w_trig),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_ent   (w_ent)
    );

    assign o_m_axis_tdata = w_ent;

endmodule
